/* sv/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg: shared constants for the block sound level meter
// Holds the register reset values, the register indexes, the level scaling
// constants and the fractional octave table.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam logic [15:0] REF_LEVEL_RESET  = 16'd30720;
    localparam logic [8:0]  SMOOTH_RESET     = 9'd77;
    localparam logic [15:0] LEVEL_RESET      = 16'd10240;
    localparam logic [17:0] DB_PER_OCTAVE_Q8 = 18'd197283;
    localparam logic [15:0] FULL_SCALE_OFFSET = 16'd23119;
    localparam logic [8:0]  SMOOTH_FULL      = 9'd256;

    localparam logic REG_REF_LEVEL = 1'b0;
    localparam logic REG_SMOOTHING = 1'b1;

    function automatic logic [9:0] frac_db(input logic [3:0] idx);
        logic [9:0] v;
        begin
            case (idx)
                4'd0:    v = 10'd0;
                4'd1:    v = 10'd67;
                4'd2:    v = 10'd131;
                4'd3:    v = 10'd191;
                4'd4:    v = 10'd248;
                4'd5:    v = 10'd302;
                4'd6:    v = 10'd354;
                4'd7:    v = 10'd403;
                4'd8:    v = 10'd451;
                4'd9:    v = 10'd496;
                4'd10:   v = 10'd540;
                4'd11:   v = 10'd582;
                4'd12:   v = 10'd622;
                4'd13:   v = 10'd661;
                4'd14:   v = 10'd699;
                default: v = 10'd735;
            endcase
            return v;
        end
    endfunction

endpackage

/* sv/block_sound_level_meter.sv */
// ----------------------------------------------------------------------------
// block_sound_level_meter: block RMS level meter in 1/256 dB
// Samples are taken one item per cycle into the block accumulator while
// the queue has room; closed blocks wait in a two-entry queue. The level
// unit then takes the block, runs a serial multiply and a restoring divide,
// checks for a zero mean square or runs the leading-one scan, forms the
// level and the smoothing, and presents the result until it is taken.
// Sample input stalls only while both queue entries are occupied.
// ----------------------------------------------------------------------------
module block_sound_level_meter
    import slm_pkg::*;
#(
    parameter int MAX_BLOCK = 512,
    parameter int MIN_BLOCK = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic               block_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        smoothed_level,
    output logic [15:0]        block_level,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [15:0]        wr_data
);

    localparam int CW   = $clog2(MAX_BLOCK + 1);
    localparam int SUMW = 16 + CW;
    localparam int SQW  = 30 + CW;
    localparam int QW   = SUMW + SQW + CW;

    logic [15:0]   ref_level_reg;
    logic [8:0]    smooth_reg;
    logic          q_full, q_push, q_pop, q_valid;
    logic [QW-1:0] q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_level_reg <= REF_LEVEL_RESET;
            smooth_reg    <= SMOOTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_REF_LEVEL: ref_level_reg <= wr_data;
                REG_SMOOTHING: smooth_reg    <= wr_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    slm_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .MIN_BLOCK (MIN_BLOCK),
        .CW        (CW),
        .SUMW      (SUMW),
        .SQW       (SQW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .block_end (block_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    slm_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_valid)
    );

    slm_back #(
        .CW   (CW),
        .SUMW (SUMW),
        .SQW  (SQW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .ref_level      (ref_level_reg),
        .smooth_factor  (smooth_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .smoothed_level (smoothed_level),
        .block_level    (block_level)
    );

endmodule

/* sv/slm_front.sv */
// ----------------------------------------------------------------------------
// slm_front: sample accumulation
// Accepts samples, keeps the block sum, sum of squares and count, and hands
// each closed block of sufficient length to the queue.
// ----------------------------------------------------------------------------
module slm_front #(
    parameter int MAX_BLOCK = 512,
    parameter int MIN_BLOCK = 16,
    parameter int CW        = 10,
    parameter int SUMW      = 26,
    parameter int SQW       = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   sample,
    input  logic                 block_end,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [SUMW+SQW+CW-1:0] q_data
);

    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic [SQW-1:0]         sumsq_reg, sumsq_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic signed [31:0]     sq;
    logic [CW-1:0]          cnt_inc;
    logic                   accept, close;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sq       = 32'(sample) * 32'(sample);
    assign cnt_inc  = cnt_reg + CW'(1);
    assign close    = block_end || (cnt_inc == CW'(MAX_BLOCK));
    assign sum_next = sum_reg + {{(SUMW-16){sample[15]}}, sample};
    assign sumsq_next = sumsq_reg + {{(SQW-32){1'b0}}, sq};
    assign cnt_next = cnt_inc;
    assign q_push   = accept && close && (cnt_inc >= CW'(MIN_BLOCK));
    assign q_data   = {sum_next, sumsq_next, cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            if (close)
            begin
                sum_reg   <= '0;
                sumsq_reg <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

/* sv/slm_queue.sv */
// ----------------------------------------------------------------------------
// slm_queue: two-entry block queue
// Decouples sample accumulation from the block level computation.
// ----------------------------------------------------------------------------
module slm_queue #(
    parameter int W = 76
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         not_empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty)) else $error("queue underflow");
`endif

endmodule

/* sv/slm_back.sv */
// ----------------------------------------------------------------------------
// slm_back: block level computation
// Forms the DC-free mean square with a serial multiplier and a restoring
// divider, converts it to decibels and applies exponential smoothing.
// ----------------------------------------------------------------------------
module slm_back
    import slm_pkg::*;
#(
    parameter int CW   = 10,
    parameter int SUMW = 26,
    parameter int SQW  = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [SUMW+SQW+CW-1:0] q_data,
    output logic                   q_pop,
    input  logic [15:0]            ref_level,
    input  logic [8:0]             smooth_factor,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            smoothed_level,
    output logic [15:0]            block_level
);

    localparam int NUMW = 2 * CW + 32;
    localparam int EW   = $clog2(NUMW);
    localparam int KW   = $clog2(NUMW + 1);
    localparam int RW   = 2 * CW + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_NORM   = 3'd3;
    localparam logic [2:0] ST_LEVEL  = 3'd4;
    localparam logic [2:0] ST_SMOOTH = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]             state_reg;
    logic [SQW-1:0]         sumsq_reg;
    logic [CW-1:0]          n_reg;
    logic [2*CW-1:0]        nsq_reg;
    logic [2*SUMW-1:0]      sum2_reg;
    logic [NUMW-1:0]        prod_reg;
    logic [NUMW-1:0]        quo_reg;
    logic [RW-1:0]          rem_reg;
    logic [KW-1:0]          cnt_reg;
    logic [EW-1:0]          e_reg;
    logic [15:0]            lvl_reg;
    logic [15:0]            avg_reg;

    logic signed [SUMW-1:0] q_sum;
    logic [SQW-1:0]         q_sumsq;
    logic [CW-1:0]          q_n;
    logic [SUMW-1:0]        sum_mag;
    logic [NUMW-1:0]        prod_step, sum2_ext;
    logic [RW-1:0]          trial, nsq_ext;
    logic                   qbit;
    logic [23:0]            oct_prod;
    logic signed [25:0]     lvl_sum;
    logic [8:0]             f_clip;
    logic [24:0]            acc;

    assign {q_sum, q_sumsq, q_n} = q_data;
    assign sum_mag   = q_sum[SUMW-1] ? SUMW'(-q_sum) : SUMW'(q_sum);
    assign prod_step = {prod_reg[NUMW-2:0], 1'b0}
                     + (n_reg[CW-1] ? {{(NUMW-SQW){1'b0}}, sumsq_reg} : '0);
    assign sum2_ext  = NUMW'(sum2_reg);
    assign trial     = {rem_reg[RW-2:0], quo_reg[NUMW-1]};
    assign nsq_ext   = {1'b0, nsq_reg};
    assign qbit      = (trial >= nsq_ext);
    assign oct_prod  = 24'(e_reg) * 24'(DB_PER_OCTAVE_Q8) + 24'd128;
    assign lvl_sum   = 26'(ref_level) + 26'(frac_db(quo_reg[NUMW-2 -: 4]))
                     + 26'(oct_prod[23:8]) - 26'(FULL_SCALE_OFFSET);
    assign f_clip    = (smooth_factor > SMOOTH_FULL) ? SMOOTH_FULL : smooth_factor;
    assign acc       = 25'(avg_reg) * 25'(SMOOTH_FULL - f_clip)
                     + 25'(lvl_reg) * 25'(f_clip) + 25'd128;

    assign q_pop          = (state_reg == ST_IDLE) && q_valid;
    assign out_valid      = (state_reg == ST_OUT);
    assign smoothed_level = avg_reg;
    assign block_level    = lvl_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sumsq_reg <= q_sumsq;
                n_reg     <= q_n;
                nsq_reg   <= (2*CW)'(q_n) * (2*CW)'(q_n);
                sum2_reg  <= (2*SUMW)'(sum_mag) * (2*SUMW)'(sum_mag);
                prod_reg  <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= prod_step;
                n_reg    <= {n_reg[CW-2:0], 1'b0};
                rem_reg  <= '0;
                quo_reg  <= (prod_reg > sum2_ext) ? (prod_reg - sum2_ext) : '0;
            end
            ST_DIV:
            begin
                rem_reg <= qbit ? (trial - nsq_ext) : trial;
                quo_reg <= {quo_reg[NUMW-2:0], qbit};
                e_reg   <= EW'(NUMW - 1);
            end
            ST_NORM:
            begin
                if (quo_reg == '0)
                begin
                    lvl_reg <= '0;
                end
                else if (!quo_reg[NUMW-1])
                begin
                    quo_reg <= {quo_reg[NUMW-2:0], 1'b0};
                    e_reg   <= e_reg - EW'(1);
                end
            end
            ST_LEVEL:
            begin
                if (lvl_sum < 0)
                begin
                    lvl_reg <= '0;
                end
                else if (lvl_sum > 26'sd65535)
                begin
                    lvl_reg <= 16'hFFFF;
                end
                else
                begin
                    lvl_reg <= lvl_sum[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            avg_reg   <= LEVEL_RESET;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= KW'(CW);
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= KW'(NUMW);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - KW'(1);
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == KW'(1))
                    begin
                        state_reg <= ST_NORM;
                    end
                    cnt_reg <= cnt_reg - KW'(1);
                end
                ST_NORM:
                begin
                    if (quo_reg == '0)
                    begin
                        state_reg <= ST_SMOOTH;
                    end
                    else if (quo_reg[NUMW-1])
                    begin
                        state_reg <= ST_LEVEL;
                    end
                end
                ST_LEVEL:
                begin
                    state_reg <= ST_SMOOTH;
                end
                ST_SMOOTH:
                begin
                    avg_reg   <= acc[23:8];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (nsq_reg != '0)) else $error("zero divisor");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(avg_reg) && $stable(lvl_reg)))
        else $error("result changed while waiting");
`endif

endmodule
